>>> rtl/lppd_pkg.sv
// lppd_pkg: shared types and constants for the length-prefixed packet deframer.
// Used by lppd_ctrl, lppd_dpath and length_prefixed_packet_deframer.
// No dependencies.
package lppd_pkg;

    // default packet buffer depth in bytes
    localparam int BUFFER_BYTES_DEF = 64;

    // two-byte little-endian length header
    localparam logic [6:0] HEADER_BYTES = 7'd2;

    // reset value of the minimum frame length register
    localparam logic [6:0] MIN_LEN_RESET = 7'd4;

    // request codes
    localparam logic REQ_DATA     = 1'b0;
    localparam logic REQ_NEW_CONN = 1'b1;

    // result kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_BAD  = 1'b1;

    // controller -> datapath commands
    typedef struct packed {
        logic accept;     // input item taken this cycle
        logic rd_issue;   // read buffer at the drain index
        logic load_byte;  // move read data into the output register
        logic load_err;   // put a bad-length result into the output register
    } cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic frame_bad;  // current item carries a bad length header
        logic frame_done; // current item completes a frame
        logic out_free;   // output register can take a result this cycle
        logic rd_last;    // drain index is on the final frame byte
    } status_t;

endpackage

>>> rtl/length_prefixed_packet_deframer.sv
// length_prefixed_packet_deframer: top level of the length-prefixed deframer.
// Instantiates lppd_ctrl and lppd_dpath; depends on lppd_pkg.
//
// Received bytes go into a packet buffer of BUFFER_BYTES entries. The first two
// bytes of a frame are a little-endian total length that counts the header. A
// length below min_frame_length (at least 2) or above BUFFER_BYTES produces one
// bad-length result (result_kind 1, last_of_frame 1), bumps the wrapping 32-bit
// bad-frame counter and drops data items until a new-connection item
// (req_type 1) arrives. A complete frame is sent as one result per byte, in
// order, with last_of_frame on the final byte. An item that produces no result
// leaves the input ready for the next item. A completed frame drains byte by
// byte: each byte is read through the single buffer read port into a register
// and then moved into the output register; input is held off while a frame
// drains or while a bad-length result waits for the output register. The
// buffer needs no clearing after reset, since only written entries are read.
// min_frame_length is written through the cfg channel, which is always ready.
module length_prefixed_packet_deframer
#(
    parameter int BUFFER_BYTES = lppd_pkg::BUFFER_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [7:0]  data_byte,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  min_frame_length,
    // result items
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [7:0]  frame_byte,
    output logic [5:0]  byte_position,
    output logic        last_of_frame,
    output logic [15:0] frame_length,
    output logic [31:0] bad_frame_count
);

    lppd_pkg::cmd_t    cmd;
    lppd_pkg::status_t st;

    // sequencing: accept, drain, error report
    lppd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // buffer, counters, header decode, output register
    lppd_dpath
    #(
        .BUFFER_BYTES (BUFFER_BYTES)
    )
    u_dpath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .req_type         (req_type),
        .data_byte        (data_byte),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .min_frame_length (min_frame_length),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .result_kind      (result_kind),
        .frame_byte       (frame_byte),
        .byte_position    (byte_position),
        .last_of_frame    (last_of_frame),
        .frame_length     (frame_length),
        .bad_frame_count  (bad_frame_count)
    );

endmodule

>>> rtl/lppd_ctrl.sv
// lppd_ctrl: controller state machine of the deframer.
// Sequences input acceptance, frame drain and error reporting.
// Depends on lppd_pkg.
module lppd_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lppd_pkg::status_t st,
    output lppd_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_LOAD = 4'b0100,
        ST_ERR  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.accept    = 1'b0;
        cmd.rd_issue  = 1'b0;
        cmd.load_byte = 1'b0;
        cmd.load_err  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    if (st.frame_bad)
                    begin
                        state_next = ST_ERR;
                    end
                    else if (st.frame_done)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (st.out_free)
                begin
                    cmd.load_byte = 1'b1;
                    state_next    = st.rd_last ? ST_IDLE : ST_READ;
                end
            end
            ST_ERR:
            begin
                if (st.out_free)
                begin
                    cmd.load_err = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/lppd_dpath.sv
// lppd_dpath: datapath of the deframer: packet buffer, fill count, header
// decode, bad-frame counter, config register and output register.
// Depends on lppd_pkg.
module lppd_dpath
#(
    parameter int BUFFER_BYTES = lppd_pkg::BUFFER_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  lppd_pkg::cmd_t    cmd,
    output lppd_pkg::status_t st,
    input  logic              req_type,
    input  logic [7:0]        data_byte,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [6:0]        min_frame_length,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              result_kind,
    output logic [7:0]        frame_byte,
    output logic [5:0]        byte_position,
    output logic              last_of_frame,
    output logic [15:0]       frame_length,
    output logic [31:0]       bad_frame_count
);

    localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int FW = $clog2(BUFFER_BYTES + 1);

    logic [7:0]    mem [BUFFER_BYTES];
    logic [7:0]    mem_q_reg;

    logic [FW-1:0] fill_reg;
    logic          discard_reg;
    logic [31:0]   bad_total_reg;
    logic [6:0]    min_len_reg;
    logic [7:0]    hdr_lo_reg;
    logic [15:0]   len_reg;
    logic [AW-1:0] rd_idx_reg;

    logic          out_valid_reg;
    logic          kind_reg;
    logic [7:0]    byte_reg;
    logic [5:0]    pos_reg;
    logic          last_reg;
    logic [15:0]   flen_reg;
    logic [31:0]   count_reg;

    logic          is_data;
    logic          hdr_step;
    logic [15:0]   len_now;
    logic [6:0]    min_len;
    logic          len_bad;
    logic [FW-1:0] fill_inc;
    logic          mem_we;
    logic [15:0]   rd_pos_wide;

    assign cfg_ready = 1'b1;

    assign is_data  = (req_type == lppd_pkg::REQ_DATA) && !discard_reg;
    assign hdr_step = (fill_reg == FW'(1));
    assign len_now  = hdr_step ? {data_byte, hdr_lo_reg} : len_reg;
    // a minimum below the header size acts as the header size
    assign min_len  = (min_len_reg < lppd_pkg::HEADER_BYTES) ? lppd_pkg::HEADER_BYTES
                                                             : min_len_reg;
    assign len_bad  = (len_now < 16'(min_len)) || (len_now > 16'(BUFFER_BYTES));
    assign fill_inc = fill_reg + FW'(1);
    assign mem_we   = cmd.accept && is_data;

    assign rd_pos_wide = 16'(rd_idx_reg);

    assign st.frame_bad  = is_data && hdr_step && len_bad;
    assign st.frame_done = is_data && (fill_reg != '0) && !(hdr_step && len_bad)
                           && (16'(fill_inc) == len_now);
    assign st.out_free   = !out_valid_reg || out_ready;
    assign st.rd_last    = ((rd_pos_wide + 16'd1) == len_reg);

    // packet buffer, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[fill_reg[AW-1:0]] <= data_byte;
        end
        if (cmd.rd_issue)
        begin
            mem_q_reg <= mem[rd_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= lppd_pkg::MIN_LEN_RESET;
        end
        else if (cfg_valid)
        begin
            min_len_reg <= min_frame_length;
        end
    end

    // frame tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            discard_reg   <= 1'b0;
            bad_total_reg <= '0;
            rd_idx_reg    <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                if (req_type == lppd_pkg::REQ_NEW_CONN)
                begin
                    fill_reg    <= '0;
                    discard_reg <= 1'b0;
                end
                else if (!discard_reg)
                begin
                    if (st.frame_bad)
                    begin
                        fill_reg      <= '0;
                        discard_reg   <= 1'b1;
                        bad_total_reg <= bad_total_reg + 32'd1;
                    end
                    else if (st.frame_done)
                    begin
                        fill_reg   <= '0;
                        rd_idx_reg <= '0;
                    end
                    else
                    begin
                        fill_reg <= fill_inc;
                    end
                end
            end
            if (cmd.load_byte)
            begin
                rd_idx_reg <= rd_idx_reg + AW'(1);
            end
        end
    end

    // header capture
    always_ff @(posedge clk)
    begin
        if (mem_we && (fill_reg == '0))
        begin
            hdr_lo_reg <= data_byte;
        end
        if (mem_we && hdr_step)
        begin
            len_reg <= len_now;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_byte || cmd.load_err)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_byte)
        begin
            kind_reg  <= lppd_pkg::KIND_BYTE;
            byte_reg  <= mem_q_reg;
            pos_reg   <= rd_pos_wide[5:0];
            last_reg  <= st.rd_last;
            flen_reg  <= len_reg;
            count_reg <= bad_total_reg;
        end
        else if (cmd.load_err)
        begin
            kind_reg  <= lppd_pkg::KIND_BAD;
            byte_reg  <= 8'd0;
            pos_reg   <= 6'd0;
            last_reg  <= 1'b1;
            flen_reg  <= len_reg;
            count_reg <= bad_total_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_kind     = kind_reg;
    assign frame_byte      = byte_reg;
    assign byte_position   = pos_reg;
    assign last_of_frame   = last_reg;
    assign frame_length    = flen_reg;
    assign bad_frame_count = count_reg;

    a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load_byte && cmd.load_err))
        else $error("byte and error result loaded together");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_byte || cmd.load_err) |-> st.out_free)
        else $error("result loaded over one not yet taken");

    a_bad_discards: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && st.frame_bad) |=> (discard_reg && (fill_reg == '0)))
        else $error("bad length did not enter discard");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(fill_reg) < BUFFER_BYTES))
        else $error("fill count beyond buffer");

endmodule
